[rtl/core/clook_pkg.sv]
`default_nettype none

package clook_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HEAD_POSITION = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SWEEP_DOWN    = 1'b1;

    // Status of one finished job, passed from the tracker to the total stage.
    typedef struct packed {
        logic seen_below;
        logic seen_from_head;
        logic sweep_down;
    } job_flags_t;

endpackage

`default_nettype wire

[rtl/core/clook_track.sv]
`default_nettype none

module clook_track #(
    parameter int unsigned CYL_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          accept,
    input  wire  [CYL_BITS-1:0]          request,
    input  wire                          last,
    input  wire  [CYL_BITS-1:0]          head,
    input  wire                          sweep_down,
    output logic [CYL_BITS-1:0]          snap_min,
    output logic [CYL_BITS-1:0]          snap_max,
    output logic [CYL_BITS-1:0]          snap_below,
    output logic [CYL_BITS-1:0]          snap_from,
    output logic [CYL_BITS-1:0]          snap_head,
    output clook_pkg::job_flags_t        snap_flags
);
    import clook_pkg::*;

    logic [CYL_BITS-1:0] min_reg, min_next;
    logic [CYL_BITS-1:0] max_reg, max_next;
    logic [CYL_BITS-1:0] below_reg, below_next;
    logic [CYL_BITS-1:0] from_reg, from_next;
    logic                seen_below_reg, seen_below_next;
    logic                seen_from_reg, seen_from_next;
    logic                is_below;

    assign is_below = request < head;

    always_comb begin
        min_next        = (request < min_reg) ? request : min_reg;
        max_next        = (request > max_reg) ? request : max_reg;
        below_next      = below_reg;
        from_next       = from_reg;
        seen_below_next = seen_below_reg;
        seen_from_next  = seen_from_reg;
        if (is_below) begin
            if (!seen_below_reg || request > below_reg) begin
                below_next = request;
            end
            seen_below_next = 1'b1;
        end else begin
            if (!seen_from_reg || request < from_reg) begin
                from_next = request;
            end
            seen_from_next = 1'b1;
        end
    end

    // Running extremes of the open job; cleared as the last request is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last)) begin
            min_reg        <= '1;
            max_reg        <= '0;
            below_reg      <= '0;
            from_reg       <= '1;
            seen_below_reg <= 1'b0;
            seen_from_reg  <= 1'b0;
        end else if (accept) begin
            min_reg        <= min_next;
            max_reg        <= max_next;
            below_reg      <= below_next;
            from_reg       <= from_next;
            seen_below_reg <= seen_below_next;
            seen_from_reg  <= seen_from_next;
        end
    end

    // Snapshot of the finished job, including its last request.
    always_ff @(posedge aclk) begin
        if (accept && last) begin
            snap_min   <= min_next;
            snap_max   <= max_next;
            snap_below <= below_next;
            snap_from  <= from_next;
            snap_head  <= head;
            snap_flags <= '{seen_below: seen_below_next,
                            seen_from_head: seen_from_next,
                            sweep_down: sweep_down};
        end
    end

endmodule

`default_nettype wire

[rtl/core/clook_sum.sv]
`default_nettype none

module clook_sum #(
    parameter int unsigned CYL_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          load,
    input  wire  [CYL_BITS-1:0]          snap_min,
    input  wire  [CYL_BITS-1:0]          snap_max,
    input  wire  [CYL_BITS-1:0]          snap_below,
    input  wire  [CYL_BITS-1:0]          snap_from,
    input  wire  [CYL_BITS-1:0]          snap_head,
    input  clook_pkg::job_flags_t        snap_flags,
    output logic [CYL_BITS+1:0]          total_reg
);
    import clook_pkg::*;

    localparam int unsigned TOTAL_BITS = CYL_BITS + 2;

    logic [CYL_BITS-1:0]   term_a, term_b, term_c;
    logic [TOTAL_BITS-1:0] total_next;

    // Difference clamped at zero, for a head moved in the middle of a job.
    function automatic logic [CYL_BITS-1:0] diff0(input logic [CYL_BITS-1:0] a,
                                                  input logic [CYL_BITS-1:0] b);
        diff0 = (a > b) ? (a - b) : '0;
    endfunction

    always_comb begin
        term_a = '0;
        term_b = '0;
        term_c = '0;
        if (!snap_flags.sweep_down) begin
            if (snap_flags.seen_from_head) begin
                term_a = diff0(snap_max, snap_head);
                if (snap_flags.seen_below) begin
                    term_b = diff0(snap_max, snap_min);
                    term_c = diff0(snap_below, snap_min);
                end
            end else begin
                term_a = diff0(snap_head, snap_min);
                term_c = diff0(snap_below, snap_min);
            end
        end else begin
            if (snap_flags.seen_below) begin
                term_a = diff0(snap_head, snap_min);
                if (snap_flags.seen_from_head) begin
                    term_b = diff0(snap_max, snap_min);
                    term_c = diff0(snap_max, snap_from);
                end
            end else begin
                term_a = diff0(snap_max, snap_head);
                term_c = diff0(snap_max, snap_from);
            end
        end
        total_next = TOTAL_BITS'(term_a) + TOTAL_BITS'(term_b) + TOTAL_BITS'(term_c);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/clook_total_seek.sv]
// Channel   Direction  Transaction content
// s_        in         tdata: request_cylinder; tlast: last_request
// m_        out        tdata: total_seek (one per job, after the last request)
// cfg_      in         write of head_position (index 0) or sweep_down (index 1)
//
// One request is taken every cycle while s_tready is high; a job's total leaves
// through the snapshot register, which captures the final extremes, and then
// the output register, which takes the three-term sum.
// Reset is synchronous and active low; it clears the job extremes, the
// configuration and both valid flags.
// A stalled output backs up into the snapshot stage, then into s_tready.
`default_nettype none

module clook_total_seek #(
    parameter int unsigned CYL_BITS = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // [CYL_BITS-1:0] request_cylinder, zero padding above
    input  wire  [((CYL_BITS+7)/8)*8-1:0]         s_tdata,
    input  wire                                   s_tlast,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // [CYL_BITS+1:0] total_seek, zero padding above
    output logic [((CYL_BITS+2+7)/8)*8-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    input  wire                                   cfg_we,
    input  wire  [clook_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire  [CYL_BITS-1:0]                   cfg_wdata
);
    import clook_pkg::*;

    localparam int unsigned TOTAL_BITS = CYL_BITS + 2;
    localparam int unsigned M_BITS     = ((CYL_BITS + 2 + 7) / 8) * 8;

    logic [CYL_BITS-1:0]   head_position_reg;
    logic                  sweep_down_reg;
    logic                  snap_valid_reg;
    logic                  out_valid_reg;
    logic                  s_accept;
    logic                  out_ready;
    logic [CYL_BITS-1:0]   snap_min, snap_max, snap_below, snap_from, snap_head;
    job_flags_t            snap_flags;
    logic [TOTAL_BITS-1:0] total_reg;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !snap_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_BITS'(total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_position_reg <= '0;
            sweep_down_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HEAD_POSITION: head_position_reg <= cfg_wdata;
                REG_SWEEP_DOWN:    sweep_down_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_ready) begin
                out_valid_reg <= snap_valid_reg;
            end
            if (s_tready) begin
                snap_valid_reg <= s_accept && s_tlast;
            end
        end
    end

    clook_track #(
        .CYL_BITS(CYL_BITS)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .request    (s_tdata[CYL_BITS-1:0]),
        .last       (s_tlast),
        .head       (head_position_reg),
        .sweep_down (sweep_down_reg),
        .snap_min   (snap_min),
        .snap_max   (snap_max),
        .snap_below (snap_below),
        .snap_from  (snap_from),
        .snap_head  (snap_head),
        .snap_flags (snap_flags)
    );

    clook_sum #(
        .CYL_BITS(CYL_BITS)
    ) u_sum (
        .aclk       (aclk),
        .load       (out_ready && snap_valid_reg),
        .snap_min   (snap_min),
        .snap_max   (snap_max),
        .snap_below (snap_below),
        .snap_from  (snap_from),
        .snap_head  (snap_head),
        .snap_flags (snap_flags),
        .total_reg  (total_reg)
    );

`ifndef SYNTHESIS
    // A finished job is never dropped while the output is stalled.
    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && !out_ready) |=> snap_valid_reg)
        else $error("job snapshot lost under stall");

    // A last request always produces a snapshot.
    a_last_snap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> snap_valid_reg)
        else $error("last request did not produce a snapshot");

    // With s_tready high and no last request taken, the snapshot stage is left empty.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && !(s_accept && s_tlast)) |=> !snap_valid_reg)
        else $error("result created without a last request");

    // A snapshot moves into the output register when it is free.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && out_ready) |=> m_tvalid)
        else $error("snapshot did not reach the output");
`endif

endmodule

`default_nettype wire
